// ----- src/banded_rate_tilt_controller_core_macros.svh -----
// Assertion macros shared by the checker of banded_rate_tilt_controller_core.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef BANDED_RATE_TILT_CONTROLLER_CORE_MACROS_SVH
`define BANDED_RATE_TILT_CONTROLLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRTC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BRTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The signal must keep its value in the cycle after the condition.
`define BRTC_ASSERT_HOLD(label, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

// ----- src/brtc_pkg.sv -----
// Package for the banded rate tilt controller: field widths, types,
// register indexes, band constants and the rate band lookup. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brtc_pkg;

    localparam int DIST_W  = 12;
    localparam int CFG_W   = 8;
    localparam int TILT_W  = 9;
    localparam int ERR_W   = DIST_W + 1;
    localparam int BAND_W  = 5;
    localparam int DIFF_W  = DIST_W + 2;
    localparam int PROD_W  = 22;
    localparam int MAG_W   = PROD_W - 1;
    localparam int QUOT_W  = 18;
    localparam int RECIP_W = 22;

    // Division by five: floor(m / 5) == (m * ceil(2^24 / 5)) >> 24 for m < 2^22.
    localparam int                 DIV5_SHIFT = 24;
    localparam logic [RECIP_W-1:0] DIV5_RECIP = 22'd3355444;

    typedef logic [DIST_W-1:0]        dist_t;
    typedef logic [CFG_W-1:0]         cfg_data_t;
    typedef logic signed [TILT_W-1:0] tilt_t;
    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic signed [BAND_W-1:0] band_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef enum logic {
        CFG_GAIN       = 1'b0,
        CFG_TILT_LIMIT = 1'b1
    } cfg_index_t;

    localparam cfg_data_t GAIN_RESET  = 8'd5;
    localparam cfg_data_t LIMIT_RESET = 8'd30;

    localparam logic [ERR_W-1:0] BAND_EDGE_1 = 13'd20;
    localparam logic [ERR_W-1:0] BAND_EDGE_2 = 13'd40;
    localparam logic [ERR_W-1:0] BAND_EDGE_3 = 13'd60;
    localparam logic [ERR_W-1:0] BAND_EDGE_4 = 13'd80;

    localparam band_t RATE_BAND_1 = 5'sd5;
    localparam band_t RATE_BAND_2 = 5'sd8;
    localparam band_t RATE_BAND_3 = 5'sd11;
    localparam band_t RATE_BAND_4 = 5'sd15;

    // Rate target for a distance error, symmetric around zero.
    function automatic band_t band_of(input err_t e);
        logic [ERR_W-1:0] mag;
        band_t            r;
        mag = e[ERR_W-1] ? $unsigned(-e) : $unsigned(e);
        if (mag < BAND_EDGE_1)
            r = '0;
        else if (mag < BAND_EDGE_2)
            r = RATE_BAND_1;
        else if (mag < BAND_EDGE_3)
            r = RATE_BAND_2;
        else if (mag < BAND_EDGE_4)
            r = RATE_BAND_3;
        else
            r = RATE_BAND_4;
        return e[ERR_W-1] ? -r : r;
    endfunction

endpackage

`default_nettype wire

// ----- src/brtc_if.sv -----
// Valid/ready channel interfaces for the banded rate tilt controller.
// Depends on brtc_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface brtc_in_if import brtc_pkg::*; ();
    logic  valid;
    logic  ready;
    dist_t distance;
    dist_t target_distance;

    modport source (output valid, output distance, output target_distance, input ready);
    modport sink   (input valid, input distance, input target_distance, output ready);
endinterface

interface brtc_out_if import brtc_pkg::*; ();
    logic  valid;
    logic  ready;
    tilt_t tilt;

    modport source (output valid, output tilt, input ready);
    modport sink   (input valid, input tilt, output ready);
endinterface

`default_nettype wire

// ----- src/banded_rate_tilt_controller_core.sv -----
// Top level of the banded rate tilt controller: history, rate bands, gain,
// divide by five and clamp. Depends on brtc_pkg and the channels in brtc_if.
`timescale 1ns / 1ps
`default_nettype none

// The controller takes one distance beat per clock on the sample channel and
// returns one tilt beat on the result channel for each of them, in order. The
// result of an accepted beat moves through the pipeline registers in order and
// is taken when the result side holds ready high. There are three pipeline
// registers: the rate error, the gain product,
// and the divided and clamped tilt, which is also the output register. Each
// holds one beat, so one beat per cycle is sustained. The sample side only
// stalls when all three are full and the result side holds ready low. The last
// HISTORY_DEPTH distances are kept in a shift line. Until it has filled, the
// rate term is zero; afterwards it is the oldest minus the newest distance in
// the window. The distance error (target minus distance) selects a rate
// target of 0, 5, 8, 11 or 15 with its sign, and the tilt is the rate target
// minus the rate term, times gain, divided by five toward zero and clamped to
// plus or minus tilt_limit. The gain and tilt_limit registers come out of
// reset as 5 and 30 and are written through cfg_we, cfg_index and cfg_data;
// they must only be written while no beat is in flight.
module banded_rate_tilt_controller_core import brtc_pkg::*; #(
    parameter int HISTORY_DEPTH = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    brtc_in_if.sink     sample,
    brtc_out_if.source  result,
    input  logic        cfg_we,
    input  cfg_index_t  cfg_index,
    input  cfg_data_t   cfg_data
);

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    // Configuration registers.
    cfg_data_t gain_reg;
    cfg_data_t limit_reg;

    // Sample history and fill count.
    logic [CNT_W-1:0] count_reg;
    dist_t            hist_reg [HISTORY_DEPTH];

    // Pipeline registers.
    logic  s1_valid_reg;
    diff_t diff_reg;
    logic  s2_valid_reg;
    prod_t prod_reg;
    logic  out_valid_reg;
    tilt_t tilt_reg;

    // Stage advance chain: a stage may load when it is empty or its content moves on.
    logic adv_out;
    logic adv_s2;
    logic adv_s1;
    logic accept;

    assign adv_out      = !out_valid_reg || result.ready;
    assign adv_s2       = !s2_valid_reg || adv_out;
    assign adv_s1       = !s1_valid_reg || adv_s2;
    assign sample.ready = adv_s1;
    assign accept       = sample.valid && adv_s1;

    // Stage 1: rate term from the history and the banded rate target.
    logic  hist_full;
    err_t  err;
    err_t  rate_term;
    band_t band;
    diff_t diff_next;

    assign hist_full = (count_reg == CNT_W'(HISTORY_DEPTH));
    assign err       = $signed({1'b0, sample.target_distance}) - $signed({1'b0, sample.distance});
    // Once full, the window after the shift starts with the current second entry.
    assign rate_term = hist_full
        ? $signed({1'b0, hist_reg[1]}) - $signed({1'b0, sample.distance})
        : '0;
    assign band      = band_of(err);
    assign diff_next = DIFF_W'(band) - DIFF_W'(rate_term);

    // Stage 2: gain multiply, signed by unsigned.
    prod_t mul_a;
    prod_t mul_b;
    prod_t prod_next;

    assign mul_a     = PROD_W'(diff_reg);
    assign mul_b     = $signed(PROD_W'({1'b0, gain_reg}));
    assign prod_next = mul_a * mul_b;

    // Stage 3: divide the magnitude by five through a reciprocal multiply,
    // clamp it to the limit and restore the sign, which truncates toward zero.
    logic                     prod_neg;
    logic [MAG_W-1:0]         prod_mag;
    logic [MAG_W+RECIP_W-1:0] quot_wide;
    logic [QUOT_W-1:0]        quot;
    logic [CFG_W-1:0]         tilt_mag;
    tilt_t                    tilt_pos;
    tilt_t                    tilt_next;

    assign prod_neg  = prod_reg[PROD_W-1];
    assign prod_mag  = prod_neg ? MAG_W'($unsigned(-prod_reg)) : MAG_W'($unsigned(prod_reg));
    assign quot_wide = prod_mag * DIV5_RECIP;
    assign quot      = quot_wide[DIV5_SHIFT +: QUOT_W];
    assign tilt_mag  = (quot > QUOT_W'(limit_reg)) ? limit_reg : quot[CFG_W-1:0];
    assign tilt_pos  = $signed({1'b0, tilt_mag});
    assign tilt_next = prod_neg ? -tilt_pos : tilt_pos;

    assign result.valid = out_valid_reg;
    assign result.tilt  = tilt_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAIN:       gain_reg  <= cfg_data;
                CFG_TILT_LIMIT: limit_reg <= cfg_data;
                default:        gain_reg  <= gain_reg;
            endcase
        end
    end

    // Fill count, saturating at the history depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept && !hist_full)
            count_reg <= count_reg + 1'b1;
    end

    // History entries: fill in order during warm-up, shift toward entry zero after.
    for (genvar i = 0; i < HISTORY_DEPTH; i++)
    begin : g_hist
        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                if (!hist_full)
                begin
                    if (count_reg == CNT_W'(i))
                        hist_reg[i] <= sample.distance;
                end
                else
                begin
                    if (i == HISTORY_DEPTH - 1)
                        hist_reg[i] <= sample.distance;
                    else
                        hist_reg[i] <= hist_reg[(i + 1) % HISTORY_DEPTH];
                end
            end
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_s1)
                s1_valid_reg <= sample.valid;
            if (adv_s2)
                s2_valid_reg <= s1_valid_reg;
            if (adv_out)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (accept)
            diff_reg <= diff_next;
        if (adv_s2 && s1_valid_reg)
            prod_reg <= prod_next;
        if (adv_out && s2_valid_reg)
            tilt_reg <= tilt_next;
    end

endmodule

`default_nettype wire

// ----- src/brtc_checker.sv -----
// Port-level checker for banded_rate_tilt_controller_core and its bind.
// Depends on banded_rate_tilt_controller_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "banded_rate_tilt_controller_core_macros.svh"

module brtc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [8:0] tilt
);

    logic in_beat;
    logic out_stall;

    assign in_beat   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    // A stalled result keeps its valid and its value.
    `BRTC_ASSERT_NEXT(a_out_valid_hold, out_stall, out_valid, "result valid dropped while stalled")
    `BRTC_ASSERT_HOLD(a_out_tilt_hold, out_stall, tilt, "result tilt changed while stalled")

    // With nothing waiting at the output, the pipeline always has room for a sample.
    `BRTC_ASSERT_IMPLY(a_ready_when_drained, !out_valid, in_ready, "sample stalled with empty output")

    // A sample reaches the output when the result side keeps ready high while it moves through the later stages.
    `BRTC_ASSERT_NEXT(a_latency, in_beat ##1 out_ready ##1 out_ready, out_valid, "result late")

endmodule

bind banded_rate_tilt_controller_core brtc_checker u_brtc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .tilt      (result.tilt)
);

`default_nettype wire

// ----- verif/brtc_tilt_checker.sv -----
// Checker for the banded rate tilt controller: watches the sample, result and
// register write ports, predicts each tilt and compares it. Depends on brtc_pkg and brtc_if.
`timescale 1ns / 1ps

module brtc_tilt_checker import brtc_pkg::*; #(
    parameter int HISTORY_DEPTH = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    brtc_in_if         sample,
    brtc_out_if        result,
    input  logic       cfg_we,
    input  cfg_index_t cfg_index,
    input  cfg_data_t  cfg_data,
    output int         fail_count,
    output int         pending
);

    localparam int EDGE_SLOW   = 20;
    localparam int EDGE_MID    = 40;
    localparam int EDGE_FAST   = 60;
    localparam int EDGE_TOP    = 80;
    localparam int RATE_SLOW   = 5;
    localparam int RATE_MID    = 8;
    localparam int RATE_FAST   = 11;
    localparam int RATE_TOP    = 15;
    localparam int TILT_DIVIDE = 5;

    cfg_data_t gain_q;
    cfg_data_t limit_q;
    int        filled;
    dist_t     window [HISTORY_DEPTH];
    tilt_t     tilt_expected [$];

    // Advances the distance window by one sample and returns the tilt it yields.
    function automatic tilt_t predict_tilt(input dist_t meas, input dist_t goal);
        int rate;
        int err;
        int mag;
        int band;
        int t;
        int i;
        rate = 0;
        if (filled < HISTORY_DEPTH) begin
            window[filled] = meas;
            filled++;
        end
        else begin
            for (i = 0; i + 1 < HISTORY_DEPTH; i++)
                window[i] = window[i + 1];
            window[HISTORY_DEPTH - 1] = meas;
            rate = int'(window[0]) - int'(window[HISTORY_DEPTH - 1]);
        end
        err = int'(goal) - int'(meas);
        mag = (err < 0) ? -err : err;
        if (mag < EDGE_SLOW)
            band = 0;
        else if (mag < EDGE_MID)
            band = RATE_SLOW;
        else if (mag < EDGE_FAST)
            band = RATE_MID;
        else if (mag < EDGE_TOP)
            band = RATE_FAST;
        else
            band = RATE_TOP;
        if (err < 0)
            band = -band;
        t = ((band - rate) * int'(gain_q)) / TILT_DIVIDE;
        if (t > int'(limit_q))
            t = int'(limit_q);
        else if (t < -int'(limit_q))
            t = -int'(limit_q);
        return tilt_t'(t);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tilt_t want;
        if (!rst_n)
        begin
            gain_q     = GAIN_RESET;
            limit_q    = LIMIT_RESET;
            filled     = 0;
            foreach (window[i])
                window[i] = '0;
            tilt_expected.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // Results are checked before new samples are queued, so a result
            // that comes out in the same cycle as its own sample is flagged.
            if (result.valid && result.ready)
            begin
                if (tilt_expected.size() == 0)
                begin
                    $error("tilt beat with no expectation waiting: actual %0d", result.tilt);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = tilt_expected.pop_front();
                    if (result.tilt !== want)
                    begin
                        $error("tilt mismatch: expected %0d, actual %0d", want, result.tilt);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (sample.valid && sample.ready)
                tilt_expected.push_back(predict_tilt(sample.distance, sample.target_distance));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GAIN:       gain_q  = cfg_data;
                    CFG_TILT_LIMIT: limit_q = cfg_data;
                    default:        ;
                endcase
            end
            pending <= tilt_expected.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top for banded_rate_tilt_controller_core: clock, reset, sample and
// register stimulus and the verdict. Depends on brtc_pkg, brtc_if and brtc_tilt_checker.
`timescale 1ns / 1ps

module tb;
    import brtc_pkg::*;

    localparam int HISTORY_DEPTH = 5;
    // Enough for every beat to wait out long receiver stalls and sender gaps,
    // several times over.
    localparam int CYCLE_LIMIT   = 200000;
    // Cycles allowed for the pipeline to drain before a register write and at the end.
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 125;
    localparam int DIST_MAX      = 4095;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;
    int         fail_count;
    int         pending;
    int         cycles;
    int         walk_pos;
    int         ready_mode;
    int         mode_left;

    brtc_in_if  sample_ch ();
    brtc_out_if result_ch ();

    banded_rate_tilt_controller_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    brtc_tilt_checker #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample_ch),
        .result     (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    // The run is cut off at a fixed cycle count in case the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side back-pressure. The receiver switches at random between modes:
    // always ready, mostly ready, mostly stalled, and a fixed pattern that drops
    // ready whenever the low three bits of the cycle counter equal five. The
    // always-ready mode gives stretches with no stalls at all.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            ready_mode      <= 0;
            mode_left       <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(20, 200);
            end
            else
                mode_left <= mode_left - 1;
            case (ready_mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= (cycles[2:0] != 3'd5);
            endcase
        end
    end

    // Presents one sample beat and returns at the edge where it is taken.
    // Valid stays high on return, so back-to-back calls form a burst.
    task automatic send_beat(input dist_t meas, input dist_t goal);
        sample_ch.valid           <= 1'b1;
        sample_ch.distance        <= meas;
        sample_ch.target_distance <= goal;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // Drops valid for a gap. A zero gap leaves valid alone so the burst
    // continues without a same-step low/high pair.
    task automatic pause_sender(input int gap);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Registers may only change with nothing in flight. The checker's pending
    // count is registered and trails the queue, so the extra settle cycles cover that too.
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers, the gain and then the limit, under one write strobe.
    task automatic write_regs(input cfg_data_t gain, input cfg_data_t limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GAIN;
        cfg_data  <= gain;
        @(posedge clk);
        cfg_index <= CFG_TILT_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic int clamp_dist(input int v);
        return (v < 0) ? 0 : (v > DIST_MAX) ? DIST_MAX : v;
    endfunction

    // Most samples follow a slow random walk, which is what a wall sensor
    // produces and what keeps the rate term inside the small bands. The rest
    // are jumps to random values, targets far off, and the field extremes.
    task automatic next_sample(output dist_t meas, output dist_t goal);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 6)
        begin
            walk_pos = clamp_dist(walk_pos + $urandom_range(0, 40) - 20);
            meas     = dist_t'(walk_pos);
            goal     = dist_t'(clamp_dist(walk_pos + $urandom_range(0, 200) - 100));
        end
        else if (pick == 7)
        begin
            meas = dist_t'($urandom);
            goal = dist_t'($urandom);
        end
        else if (pick == 8)
        begin
            meas = dist_t'(walk_pos);
            goal = dist_t'($urandom);
        end
        else
        begin
            meas = ($urandom_range(0, 1) != 0) ? dist_t'(DIST_MAX) : '0;
            goal = ($urandom_range(0, 1) != 0) ? dist_t'(DIST_MAX) : '0;
        end
    endtask

    function automatic cfg_data_t pick_reg_value();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return 8'hFF;
        else
            return cfg_data_t'($urandom);
    endfunction

    initial
    begin
        dist_t meas;
        dist_t goal;
        int    sent;
        int    burst;

        rst_n                     = 1'b0;
        cycles                    = 0;
        cfg_we                    = 1'b0;
        cfg_index                 = CFG_GAIN;
        cfg_data                  = '0;
        sample_ch.valid           = 1'b0;
        sample_ch.distance        = '0;
        sample_ch.target_distance = '0;
        result_ch.ready           = 1'b0;
        walk_pos                  = 2048;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part with the reset register values. The first five beats
        // are the warm-up, where the rate term is zero and each one lands right at
        // a band edge, on one side or the other. Holding the distance at 2000 then
        // lets the window settle until the rate term is zero again.
        send_beat(12'd0,    12'd19);
        send_beat(12'd0,    12'd20);
        send_beat(12'd4095, 12'd4056);
        send_beat(12'd2000, 12'd2040);
        send_beat(12'd2000, 12'd1941);
        send_beat(12'd2000, 12'd2060);
        send_beat(12'd2000, 12'd1921);
        pause_sender(3);
        send_beat(12'd2000, 12'd2080);
        send_beat(12'd2000, 12'd4095);
        send_beat(12'd2000, 12'd0);
        send_beat(12'd2000, 12'd1980);
        send_beat(12'd2000, 12'd2079);
        send_beat(12'd4095, 12'd0);
        send_beat(12'd0,    12'd4095);
        pause_sender(1);
        wait_drained();

        // Zero gain must give zero tilt whatever the rate error.
        write_regs(8'd0, 8'hFF);
        send_beat(12'd0,    12'd4095);
        send_beat(12'd4095, 12'd0);
        send_beat(12'd100,  12'd4095);
        pause_sender(1);
        wait_drained();

        // Zero limit clamps everything to zero even at full gain.
        write_regs(8'hFF, 8'd0);
        send_beat(12'd4095, 12'd0);
        send_beat(12'd0,    12'd4095);
        pause_sender(1);
        wait_drained();

        // Full gain and limit: the product reaches its widest range.
        write_regs(8'hFF, 8'hFF);
        send_beat(12'd4095, 12'd4095);
        send_beat(12'd0,    12'd0);
        send_beat(12'd4095, 12'd0);
        pause_sender(1);
        wait_drained();

        // Random phases, each with its own register setting. Phase 0 pins the limit
        // at its maximum and phase 1 sets the gain to one.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                write_regs(pick_reg_value(), 8'hFF);
            else if (phase == 1)
                write_regs(8'd1, pick_reg_value());
            else
                write_regs(pick_reg_value(), pick_reg_value());
            sent = 0;
            while (sent < PHASE_BEATS)
            begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst && sent < PHASE_BEATS; b++)
                begin
                    next_sample(meas, goal);
                    send_beat(meas, goal);
                    sent++;
                end
                if ($urandom_range(0, 3) == 0)
                    pause_sender(0);
                else
                    pause_sender($urandom_range(1, 6));
            end
            pause_sender(1);
            wait_drained();
        end

        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/brtc_pkg.sv
src/brtc_if.sv
src/banded_rate_tilt_controller_core.sv
src/brtc_checker.sv
verif/brtc_tilt_checker.sv
verif/tb.sv
